[hw/rtl/adsr_pkg.sv]
package adsr_pkg;

    // field widths
    localparam int unsigned LEN_W  = 20;
    localparam int unsigned SUS_W  = 17;
    localparam int unsigned COEF_W = 16;
    localparam int unsigned GATE_W = 18;
    localparam int unsigned LVL_W  = 34;
    localparam int unsigned LEFT_W = 21;
    localparam int unsigned NUM_W  = 35;
    localparam int unsigned MA_W   = 35;
    localparam int unsigned MB_W   = 17;
    localparam int unsigned PROD_W = 52;
    localparam int unsigned WIDE_W = 37;

    // item kinds on the input tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_GATE = 2'd1;
    localparam logic [1:0] OP_BANG = 2'd2;

    // configuration register indexes
    localparam logic [3:0] REG_ATTACK_LEN   = 4'd0;
    localparam logic [3:0] REG_DECAY_LEN    = 4'd1;
    localparam logic [3:0] REG_RELEASE_LEN  = 4'd2;
    localparam logic [3:0] REG_SUSTAIN      = 4'd3;
    localparam logic [3:0] REG_LOG_MODE     = 4'd4;
    localparam logic [3:0] REG_ATTACK_COEF  = 4'd5;
    localparam logic [3:0] REG_DECAY_COEF   = 4'd6;
    localparam logic [3:0] REG_RELEASE_COEF = 4'd7;

    typedef logic signed [LVL_W-1:0]  t_lvl;
    typedef logic signed [GATE_W-1:0] t_gate;
    typedef logic signed [NUM_W-1:0]  t_num;

    // per-channel stored state
    typedef struct packed {
        t_lvl              lvl;
        t_gate             tgt;
        t_lvl              inc;
        logic [LEFT_W-1:0] left;
    } t_chan_st;

    // clamp a wide value to the level range
    function automatic t_lvl sat_lvl(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(signed'({1'b0, {(LVL_W-1){1'b1}}}));
        lo = -hi - WIDE_W'(1);
        if (v > hi) begin
            return t_lvl'(hi);
        end else if (v < lo) begin
            return t_lvl'(lo);
        end
        return v[LVL_W-1:0];
    endfunction

endpackage

[hw/rtl/adsr_envelope_generator_core.sv]
// multichannel adsr envelope generator
// input stream: tuser carries the item kind (tick, control gate, bang); tdata carries
// channel, signed q2.16 gate level and the retrigger flag. output stream: tdata carries
// channel, signed q2.16 level, active and active-changed; tuser is the sample flag
// (0 for a status-only result from a control item).
// configuration: write channel with register index and data, always ready; write only
// while the block is idle.
// a control item gives a status result only when it wakes channel zero. a tick gives its
// result through these steps in order: a state read, an optional bit-serial divide for
// a new segment, a serial multiply for the sustain level, then a second divide (linear
// decay) or multiply (exponential step), a saturating add and a write-back.
// one item is in work at a time; the next item is taken once the result sits in the
// output register, which holds it while the receiver stalls.
// reset clears configuration to defaults, all channel state to zero (through per-channel
// valid bits) and the output register's valid flag.
module adsr_envelope_generator_core #(
    parameter int CHANNELS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // channel[3:0], gate_level[21:4], retrig[22], zero
    input  logic [1:0]  i_s_tuser,   // op[1:0]
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // out_channel[3:0], level[21:4], active[22],
                                     // active_changed[23]
    output logic        o_m_tuser,   // sample_valid[0]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned LW = adsr_pkg::LEN_W;
    localparam int unsigned FW = adsr_pkg::LEFT_W;
    localparam int unsigned NW = adsr_pkg::NUM_W;
    localparam int unsigned WW = adsr_pkg::WIDE_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_LD   = 4'd2;
    localparam logic [3:0] S_EV   = 4'd3;
    localparam logic [3:0] S_DIV1 = 4'd4;
    localparam logic [3:0] S_MSQ  = 4'd5;
    localparam logic [3:0] S_WSQ  = 4'd6;
    localparam logic [3:0] S_STEP = 4'd7;
    localparam logic [3:0] S_DIV2 = 4'd8;
    localparam logic [3:0] S_WMUL = 4'd9;
    localparam logic [3:0] S_ADD  = 4'd10;
    localparam logic [3:0] S_WB   = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    // configuration registers
    logic [LW-1:0]                   r_alen, r_dlen, r_rlen;
    logic [adsr_pkg::SUS_W-1:0]      r_sus;
    logic                            r_log;
    logic [adsr_pkg::COEF_W-1:0]     r_acoef, r_dcoef, r_rcoef;

    // control state
    logic [3:0]                      r_state;
    adsr_pkg::t_gate                 r_cg;
    adsr_pkg::t_gate                 r_lnz;
    logic                            r_pend;
    logic [CHANNELS-1:0]             r_vld;
    logic [CHANNELS-1:0]             r_gopen;
    logic [CHANNELS-1:0]             r_act;

    // item in work
    logic [AW-1:0]                   r_addr;
    logic [3:0]                      r_ch;
    adsr_pkg::t_gate                 r_g;
    logic                            r_rt;
    logic                            r_was;
    adsr_pkg::t_lvl                  r_lvl;
    adsr_pkg::t_gate                 r_tgt;
    adsr_pkg::t_lvl                  r_inc;
    logic [FW-1:0]                   r_left;
    adsr_pkg::t_lvl                  r_sq;
    adsr_pkg::t_lvl                  r_goal;

    // state memory
    adsr_pkg::t_chan_st              mem [CHANNELS];
    adsr_pkg::t_chan_st              r_rdata;

    // result staging and output register
    logic [23:0]                     r_res;
    logic                            r_res_sv;
    logic                            r_ovld;
    logic [23:0]                     r_odata;
    logic                            r_ouser;

    // serial units
    logic                            r_dstart;
    adsr_pkg::t_num                  r_dnum;
    logic [LW-1:0]                   r_dden;
    logic                            div_done;
    adsr_pkg::t_lvl                  div_quo;
    logic                            r_mstart;
    logic signed [adsr_pkg::MA_W-1:0] r_ma;
    logic [adsr_pkg::MB_W-1:0]       r_mb;
    logic                            mul_done;
    logic signed [adsr_pkg::PROD_W-1:0] mul_prod;

    // decoded input and derived config
    logic [3:0]                      in_ch;
    adsr_pkg::t_gate                 in_g;
    logic                            in_acc;
    logic [LW-1:0]                   na, nd, nr;
    logic [adsr_pkg::SUS_W-1:0]      sus;
    logic                            gopen_cur;
    logic                            open_now;
    adsr_pkg::t_gate                 tsel;
    adsr_pkg::t_num                  att_num;
    adsr_pkg::t_lvl                  tq;
    logic                            in_decay;
    logic signed [WW-1:0]            exp_sh;
    logic signed [NW:0]              out_rnd;
    logic [17:0]                     out_lvl;

    assign in_ch  = i_s_tdata[3:0];
    assign in_g   = i_s_tdata[21:4];
    assign in_acc = i_s_tvalid && o_s_tready;

    assign na  = (r_alen == '0) ? LW'(1) : r_alen;
    assign nd  = (r_dlen == '0) ? LW'(1) : r_dlen;
    assign nr  = (r_rlen == '0) ? LW'(1) : r_rlen;
    assign sus = (r_sus > adsr_pkg::SUS_W'(65536)) ? adsr_pkg::SUS_W'(65536) : r_sus;

    // segment event terms
    assign gopen_cur = r_gopen[r_addr];
    assign open_now  = (r_g != '0) || (r_cg != '0);
    always_comb begin
        if (r_pend) begin
            tsel = r_cg;
        end else if (open_now != gopen_cur) begin
            tsel = (r_cg != '0) ? r_cg : r_g;
        end else begin
            tsel = r_tgt;
        end
    end
    assign att_num  = NW'(signed'({tsel, 16'd0})) - NW'(r_lvl);
    assign tq       = signed'({r_tgt, 16'd0});
    assign in_decay = r_left <= {1'b0, nd};

    // exponential step: goal + round((level - goal) * coef / 65536)
    assign exp_sh  = WW'((mul_prod + adsr_pkg::PROD_W'(32768)) >>> 16);

    // output rounding and clamp
    assign out_rnd = ((NW+1)'(r_lvl) + (NW+1)'(32768)) >>> 16;
    always_comb begin
        if (out_rnd > (NW+1)'(131071)) begin
            out_lvl = 18'h1FFFF;
        end else if (out_rnd < -(NW+1)'(131072)) begin
            out_lvl = 18'h20000;
        end else begin
            out_lvl = out_rnd[17:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alen  <= LW'(480);
            r_dlen  <= LW'(480);
            r_rlen  <= LW'(480);
            r_sus   <= adsr_pkg::SUS_W'(65536);
            r_log   <= 1'b1;
            r_acoef <= adsr_pkg::COEF_W'(64599);
            r_dcoef <= adsr_pkg::COEF_W'(64599);
            r_rcoef <= adsr_pkg::COEF_W'(64599);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                adsr_pkg::REG_ATTACK_LEN:   r_alen  <= i_cfg_data;
                adsr_pkg::REG_DECAY_LEN:    r_dlen  <= i_cfg_data;
                adsr_pkg::REG_RELEASE_LEN:  r_rlen  <= i_cfg_data;
                adsr_pkg::REG_SUSTAIN:      r_sus   <= i_cfg_data[adsr_pkg::SUS_W-1:0];
                adsr_pkg::REG_LOG_MODE:     r_log   <= i_cfg_data[0];
                adsr_pkg::REG_ATTACK_COEF:  r_acoef <= i_cfg_data[adsr_pkg::COEF_W-1:0];
                adsr_pkg::REG_DECAY_COEF:   r_dcoef <= i_cfg_data[adsr_pkg::COEF_W-1:0];
                adsr_pkg::REG_RELEASE_COEF: r_rcoef <= i_cfg_data[adsr_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // channel state memory
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[r_addr];
        if (r_state == S_WB) begin
            mem[r_addr] <= '{lvl: r_lvl, tgt: r_tgt, inc: r_inc, left: r_left};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cg     <= '0;
            r_lnz    <= adsr_pkg::GATE_W'(65536);
            r_pend   <= 1'b0;
            r_vld    <= '0;
            r_gopen  <= '0;
            r_act    <= '0;
            r_dstart <= 1'b0;
            r_mstart <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            r_mstart <= 1'b0;
            if (r_ovld && i_m_tready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ch   <= in_ch;
                        r_g    <= in_g;
                        r_rt   <= i_s_tdata[22];
                        r_addr <= AW'(in_ch);
                        if ((i_s_tuser == adsr_pkg::OP_GATE && in_g != '0)
                                || i_s_tuser == adsr_pkg::OP_BANG) begin
                            if (i_s_tuser == adsr_pkg::OP_GATE) begin
                                r_cg  <= in_g;
                                r_lnz <= in_g;
                            end else begin
                                r_cg <= r_lnz;
                            end
                            // trigger on channel zero
                            if (!r_act[0]) begin
                                r_act[0] <= 1'b1;
                                r_res    <= {2'b11, 22'd0};
                                r_res_sv <= 1'b0;
                                r_state  <= S_OUT;
                            end else begin
                                r_pend <= 1'b1;
                            end
                        end else if (i_s_tuser == adsr_pkg::OP_GATE) begin
                            r_cg <= '0;
                        end else if (i_s_tuser == adsr_pkg::OP_TICK
                                && 32'(in_ch) < CHANNELS) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_LD;
                end
                S_LD: begin
                    r_was <= r_act[r_addr];
                    if (r_vld[r_addr]) begin
                        r_lvl  <= r_rdata.lvl;
                        r_tgt  <= r_rdata.tgt;
                        r_inc  <= r_rdata.inc;
                        r_left <= r_rdata.left;
                    end else begin
                        r_lvl  <= '0;
                        r_tgt  <= '0;
                        r_inc  <= '0;
                        r_left <= '0;
                    end
                    r_state <= S_EV;
                end
                S_EV: begin
                    r_tgt   <= tsel;
                    r_state <= S_MSQ;
                    // retrigger, gate change or audio retrigger start a segment
                    if (r_pend || (open_now == gopen_cur && gopen_cur && r_rt)
                            || (open_now != gopen_cur && open_now)) begin
                        r_pend          <= 1'b0;
                        r_gopen[r_addr] <= 1'b1;
                        if (!r_pend) begin
                            r_act[r_addr] <= r_act[r_addr] | (open_now != gopen_cur);
                        end
                        r_dnum   <= att_num;
                        r_dden   <= na;
                        r_left   <= FW'(na) + FW'(nd);
                        r_dstart <= 1'b1;
                        r_state  <= S_DIV1;
                    end else if (open_now != gopen_cur) begin
                        r_gopen[r_addr] <= 1'b0;
                        r_dnum   <= -NW'(r_lvl);
                        r_dden   <= nr;
                        r_left   <= FW'(nr);
                        r_dstart <= 1'b1;
                        r_state  <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_inc   <= div_quo;
                        r_state <= S_MSQ;
                    end
                end
                S_MSQ: begin
                    r_ma     <= adsr_pkg::MA_W'(r_tgt);
                    r_mb     <= sus;
                    r_mstart <= 1'b1;
                    r_state  <= S_WSQ;
                end
                S_WSQ: begin
                    if (mul_done) begin
                        r_sq    <= mul_prod[adsr_pkg::LVL_W-1:0];
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_left != '0) begin
                        r_left <= r_left - FW'(1);
                        if (gopen_cur && !r_log) begin
                            if (in_decay) begin
                                r_dnum   <= NW'(r_sq) - NW'(tq);
                                r_dden   <= nd;
                                r_dstart <= 1'b1;
                                r_state  <= S_DIV2;
                            end else begin
                                r_state <= S_ADD;
                            end
                        end else if (!r_log) begin
                            r_state <= S_ADD;
                        end else begin
                            // exponential segment toward its goal
                            if (gopen_cur && in_decay) begin
                                r_goal <= r_sq;
                                r_ma   <= adsr_pkg::MA_W'(r_lvl) - adsr_pkg::MA_W'(r_sq);
                                r_mb   <= adsr_pkg::MB_W'(r_dcoef);
                            end else begin
                                r_goal <= tq;
                                r_ma   <= adsr_pkg::MA_W'(r_lvl) - adsr_pkg::MA_W'(tq);
                                r_mb   <= gopen_cur ? adsr_pkg::MB_W'(r_acoef)
                                                    : adsr_pkg::MB_W'(r_rcoef);
                            end
                            r_mstart <= 1'b1;
                            r_state  <= S_WMUL;
                        end
                    end else if (gopen_cur) begin
                        r_lvl   <= r_sq;
                        r_state <= S_WB;
                    end else begin
                        r_act[r_addr] <= 1'b0;
                        r_lvl         <= '0;
                        r_state       <= S_WB;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_inc   <= div_quo;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_lvl   <= adsr_pkg::sat_lvl(WW'(r_lvl) + WW'(r_inc));
                    r_state <= S_WB;
                end
                S_WMUL: begin
                    if (mul_done) begin
                        r_lvl   <= adsr_pkg::sat_lvl(exp_sh + WW'(r_goal));
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_vld[r_addr] <= 1'b1;
                    r_res    <= {r_act[r_addr] != r_was, r_act[r_addr], out_lvl, r_ch};
                    r_res_sv <= 1'b1;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    // load the output register once it is free
                    if (!r_ovld || i_m_tready) begin
                        r_ovld  <= 1'b1;
                        r_odata <= r_res;
                        r_ouser <= r_res_sv;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    adsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    adsr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_ovld;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ouser;
    assign o_cfg_ready = 1'b1;

    // a status-only result is always channel zero turning active
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[23:22] == 2'b11 && o_m_tdata[3:0] == 4'd0))
        else $error("status result malformed");

    // the two serial units never finish together
    a_units_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_done && mul_done))
        else $error("divider and multiplier overlap");

    // the divider only finishes while the sequencer waits for it
    a_wait_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("divider result not awaited");

endmodule

[hw/rtl/adsr_div.sv]
module adsr_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  adsr_pkg::t_num           i_num,
    input  logic [adsr_pkg::LEN_W-1:0] i_den,
    output logic                     o_done,
    output adsr_pkg::t_lvl           o_quo
);

    localparam int unsigned NW = adsr_pkg::NUM_W;
    localparam int unsigned DW = adsr_pkg::LEN_W;

    logic          r_busy;
    logic          r_done;
    logic [5:0]    r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_sh;
    logic [DW-1:0] r_den;
    logic          r_neg;
    logic [DW:0]   trial;
    logic          fits;
    logic signed [adsr_pkg::WIDE_W-1:0] q_wide;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_sh[NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // magnitude shift register and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_sh  <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_neg <= i_num[NW-1];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? DW'(trial - {1'b0, r_den}) : trial[DW-1:0];
            r_sh  <= {r_sh[NW-2:0], fits};
        end
    end

    // sign and clamp of the quotient
    assign q_wide = r_neg ? -signed'({2'b00, r_sh}) : signed'({2'b00, r_sh});
    assign o_quo  = adsr_pkg::sat_lvl(q_wide);
    assign o_done = r_done;

endmodule

[hw/rtl/adsr_mul.sv]
module adsr_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [adsr_pkg::MA_W-1:0]    i_a,
    input  logic [adsr_pkg::MB_W-1:0]           i_b,
    output logic                                o_done,
    output logic signed [adsr_pkg::PROD_W-1:0]  o_prod
);

    localparam int unsigned PW = adsr_pkg::PROD_W;
    localparam int unsigned BW = adsr_pkg::MB_W;

    logic                                r_busy;
    logic                                r_done;
    logic [4:0]                          r_cnt;
    logic signed [adsr_pkg::MA_W-1:0]    r_a;
    logic [BW-1:0]                       r_b;
    logic signed [PW-1:0]                r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // shift-add, multiplier bits from the top down
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= (r_acc <<< 1) + (r_b[BW-1] ? PW'(r_a) : PW'(0));
            r_b   <= {r_b[BW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int          NCH        = 16;
    localparam logic [1:0]  OP_NONE    = 2'd3;
    localparam int          SETTLE     = 200;
    localparam longint      CYCLE_CAP  = 1000000;
    localparam longint      LVL_TOP    = 64'sd8589934591;
    localparam longint      LVL_BOTTOM = -64'sd8589934592;

    // one envelope result as seen on the output stream
    typedef struct {
        logic [3:0]                  chan;
        logic [adsr_pkg::GATE_W-1:0] level;
        logic                        smp;
        logic                        act;
        logic                        chg;
    } t_env_result;

    // envelope predictor and the results it still owes
    class envelope_board;
        t_env_result pending_q[$];
        int          fails;
        int unsigned len_a, len_d, len_r, sus_reg, log_on, coef_a, coef_d, coef_r;
        longint      lvl_st[NCH];
        int          tgt_st[NCH];
        longint      inc_st[NCH];
        int unsigned left_st[NCH];
        bit          open_st[NCH];
        bit          act_st[NCH];
        int          ctl_gate;
        int          last_gate;
        bit          retrig_queued;

        function new();
            len_a = 480; len_d = 480; len_r = 480;
            sus_reg = 65536; log_on = 1;
            coef_a = 64599; coef_d = 64599; coef_r = 64599;
            for (int c = 0; c < NCH; c++) begin
                lvl_st[c] = 0; tgt_st[c] = 0; inc_st[c] = 0; left_st[c] = 0;
                open_st[c] = 0; act_st[c] = 0;
            end
            ctl_gate = 0; last_gate = 65536; retrig_queued = 0; fails = 0;
        endfunction

        function longint clamp_lvl(longint v);
            if (v > LVL_TOP) return LVL_TOP;
            if (v < LVL_BOTTOM) return LVL_BOTTOM;
            return v;
        endfunction

        // floor((v + half) / 2^16)
        function longint round16(longint v);
            longint t;
            t = v + 32768;
            if (t >= 0) return t >>> 16;
            return -((-t + 65535) >>> 16);
        endfunction

        function longint pole_step(longint l, longint goal, int unsigned cf);
            return clamp_lvl(goal + round16((l - goal) * longint'(cf)));
        endfunction

        function void write_reg(logic [3:0] idx, logic [19:0] d);
            case (idx)
                adsr_pkg::REG_ATTACK_LEN:   len_a = d;
                adsr_pkg::REG_DECAY_LEN:    len_d = d;
                adsr_pkg::REG_RELEASE_LEN:  len_r = d;
                adsr_pkg::REG_SUSTAIN:      sus_reg = d[16:0];
                adsr_pkg::REG_LOG_MODE:     log_on = d[0];
                adsr_pkg::REG_ATTACK_COEF:  coef_a = d[15:0];
                adsr_pkg::REG_DECAY_COEF:   coef_d = d[15:0];
                adsr_pkg::REG_RELEASE_COEF: coef_r = d[15:0];
                default: ;
            endcase
        endfunction

        // channel zero activation by a control item
        function void wake_chan0();
            t_env_result r;
            if (!act_st[0]) begin
                act_st[0] = 1;
                r.chan = '0; r.level = '0; r.smp = 1'b0; r.act = 1'b1; r.chg = 1'b1;
                pending_q.push_back(r);
            end else begin
                retrig_queued = 1;
            end
        endfunction

        function void note_item(logic [1:0] op, logic [3:0] ch, logic signed [17:0] g,
                                logic rt);
            longint      na, nd, nr, sus, l, tq, sq, o;
            bit          was, open_now;
            int          c;
            t_env_result r;
            if (op == adsr_pkg::OP_GATE) begin
                ctl_gate = g;
                if (g == 0) return;
                last_gate = g;
                wake_chan0();
                return;
            end
            if (op == adsr_pkg::OP_BANG) begin
                ctl_gate = last_gate;
                wake_chan0();
                return;
            end
            if (op != adsr_pkg::OP_TICK || ch >= NCH) return;
            c = ch;
            na = (len_a == 0) ? 1 : len_a;
            nd = (len_d == 0) ? 1 : len_d;
            nr = (len_r == 0) ? 1 : len_r;
            sus = (sus_reg > 65536) ? 65536 : sus_reg;
            was = act_st[c];
            l = lvl_st[c];
            open_now = (g != 0) || (ctl_gate != 0);
            // segment start: queued retrigger, gate edge or retrigger pulse
            if (retrig_queued) begin
                tgt_st[c] = ctl_gate;
                inc_st[c] = clamp_lvl((longint'(tgt_st[c]) * 65536 - l) / na);
                left_st[c] = na + nd;
                retrig_queued = 0;
                open_st[c] = 1;
            end else if (open_now != open_st[c]) begin
                open_st[c] = open_now;
                tgt_st[c] = (ctl_gate != 0) ? ctl_gate : int'(g);
                if (open_now) begin
                    act_st[c] = 1;
                    inc_st[c] = clamp_lvl((longint'(tgt_st[c]) * 65536 - l) / na);
                    left_st[c] = na + nd;
                end else begin
                    inc_st[c] = clamp_lvl((-l) / nr);
                    left_st[c] = nr;
                end
            end else if (open_st[c] && rt) begin
                inc_st[c] = clamp_lvl((longint'(tgt_st[c]) * 65536 - l) / na);
                left_st[c] = na + nd;
            end
            tq = longint'(tgt_st[c]) * 65536;
            sq = longint'(tgt_st[c]) * sus;
            // one sample of the current segment
            if (open_st[c]) begin
                if (left_st[c] > 0) begin
                    if (!log_on) begin
                        if (left_st[c] <= nd) inc_st[c] = clamp_lvl((sq - tq) / nd);
                        l = clamp_lvl(l + inc_st[c]);
                    end else if (left_st[c] <= nd) begin
                        l = pole_step(l, sq, coef_d);
                    end else begin
                        l = pole_step(l, tq, coef_a);
                    end
                    left_st[c]--;
                end else begin
                    l = sq;
                end
            end else begin
                if (left_st[c] > 0) begin
                    if (log_on) l = pole_step(l, tq, coef_r);
                    else l = clamp_lvl(l + inc_st[c]);
                    left_st[c]--;
                end else begin
                    act_st[c] = 0;
                    l = 0;
                end
            end
            lvl_st[c] = l;
            o = round16(l);
            if (o > 131071) o = 131071;
            if (o < -131072) o = -131072;
            r.chan = ch; r.level = o[17:0]; r.smp = 1'b1;
            r.act = act_st[c]; r.chg = (act_st[c] != was);
            pending_q.push_back(r);
        endfunction

        function void check_result(t_env_result got);
            t_env_result w;
            if (pending_q.size() == 0) begin
                $error("unexpected result on channel %0d", got.chan);
                fails++;
                return;
            end
            w = pending_q.pop_front();
            if (got.chan !== w.chan) begin
                $error("out_channel expected %0d actual %0d", w.chan, got.chan); fails++;
            end
            if (got.level !== w.level) begin
                $error("level expected %0d actual %0d", $signed(w.level),
                       $signed(got.level));
                fails++;
            end
            if (got.smp !== w.smp) begin
                $error("sample_valid expected %0d actual %0d", w.smp, got.smp); fails++;
            end
            if (got.act !== w.act) begin
                $error("active expected %0d actual %0d", w.act, got.act); fails++;
            end
            if (got.chg !== w.chg) begin
                $error("active_changed expected %0d actual %0d", w.chg, got.chg); fails++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;

    envelope_board board = new();
    bit            calm = 0;
    longint        cycles = 0;
    int            stall_left = 0;
    logic signed [17:0] chan_gate[NCH];

    adsr_envelope_generator_core #(.CHANNELS(NCH)) dut (.*);

    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: check each transfer, stall in bursts
    always @(posedge i_clk) begin
        t_env_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.chan = o_m_tdata[3:0]; got.level = o_m_tdata[21:4];
            got.act = o_m_tdata[22]; got.chg = o_m_tdata[23]; got.smp = o_m_tuser;
            board.check_result(got);
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            i_m_tready <= 0;
        end else begin
            i_m_tready <= 1;
        end
    end

    // one input transfer, with an occasional idle burst ahead of it
    task automatic send_item(logic [1:0] op, logic [3:0] ch, logic signed [17:0] g,
                             logic rt);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 12);
            i_s_tvalid <= 0;
            repeat (n) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= op;
        i_s_tdata <= {1'b0, rt, g, ch};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_item(op, ch, g, rt);
    endtask

    // valid stays high across a run of writes; the caller drops it afterwards
    task automatic cfg_write(logic [3:0] idx, logic [19:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, d);
    endtask

    // drain outstanding results, then let a dropped item finish
    task automatic wait_idle();
        i_s_tvalid <= 0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [19:0] pick_len(int kind);
        case (kind)
            0: return 20'd0;
            1: return 20'd1;
            2: return 20'hFFFFF;
            default: return 20'($urandom_range(0, 24));
        endcase
    endfunction

    function automatic logic signed [17:0] pick_gate();
        case ($urandom_range(0, 5))
            0: return 18'sh1FFFF;
            1: return -18'sh20000;
            2: return 18'sd65536;
            default: return 18'($urandom());
        endcase
    endfunction

    task automatic set_phase(int p);
        logic [19:0] sus;
        case (p % 4)
            0: sus = 20'd0;
            1: sus = 20'd65536;
            2: sus = {3'($urandom_range(0, 7)), 17'h1FFFF};
            default: sus = 20'($urandom());
        endcase
        cfg_write(adsr_pkg::REG_ATTACK_LEN,
                  pick_len(p == 2 ? 2 : int'($urandom_range(0, 5))));
        cfg_write(adsr_pkg::REG_DECAY_LEN,
                  pick_len(p == 3 ? 2 : int'($urandom_range(0, 5))));
        cfg_write(adsr_pkg::REG_RELEASE_LEN,
                  pick_len(p == 5 ? 2 : int'($urandom_range(0, 5))));
        cfg_write(adsr_pkg::REG_SUSTAIN, sus);
        cfg_write(adsr_pkg::REG_LOG_MODE, {19'($urandom_range(0, 1023)), p[0]});
        cfg_write(adsr_pkg::REG_ATTACK_COEF,
                  p == 1 ? 20'h0 : (p == 4 ? 20'hFFFF : 20'($urandom())));
        cfg_write(adsr_pkg::REG_DECAY_COEF,
                  p == 4 ? 20'h0 : (p == 1 ? 20'hFFFF : 20'($urandom())));
        cfg_write(adsr_pkg::REG_RELEASE_COEF, p == 6 ? 20'hFFFF : 20'($urandom()));
        i_cfg_valid <= 0;
    endtask

    initial begin
        int            pick;
        int            ch;
        logic signed [17:0] g;
        for (int c = 0; c < NCH; c++) chan_gate[c] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: control items, extremes and the unused op at reset settings
        send_item(adsr_pkg::OP_GATE, 4'd0, 18'sh1FFFF, 1'b0);
        send_item(adsr_pkg::OP_BANG, 4'd0, 18'sd0, 1'b0);
        send_item(adsr_pkg::OP_TICK, 4'd3, 18'sd0, 1'b0);
        send_item(adsr_pkg::OP_GATE, 4'd0, 18'sd0, 1'b0);
        send_item(adsr_pkg::OP_TICK, 4'd15, -18'sh20000, 1'b1);
        send_item(adsr_pkg::OP_TICK, 4'd15, -18'sh20000, 1'b1);
        send_item(adsr_pkg::OP_TICK, 4'd5, 18'sh1FFFF, 1'b0);
        send_item(OP_NONE, 4'd5, 18'sh2AAAA, 1'b1);
        send_item(adsr_pkg::OP_TICK, 4'd5, 18'sd0, 1'b0);
        send_item(adsr_pkg::OP_TICK, 4'd5, 18'sd0, 1'b1);
        send_item(adsr_pkg::OP_BANG, 4'd9, 18'sh15555, 1'b1);
        send_item(adsr_pkg::OP_TICK, 4'd10, 18'sd0, 1'b0);
        wait_idle();
        cfg_write(adsr_pkg::REG_ATTACK_LEN, 20'd1);
        cfg_write(adsr_pkg::REG_DECAY_LEN, 20'd0);
        cfg_write(adsr_pkg::REG_RELEASE_LEN, 20'd1);
        cfg_write(adsr_pkg::REG_LOG_MODE, 20'd0);
        i_cfg_valid <= 0;
        for (int k = 0; k < 6; k++) send_item(adsr_pkg::OP_TICK, 4'd15, 18'sh1FFFF, k == 3);
        for (int k = 0; k < 4; k++) send_item(adsr_pkg::OP_TICK, 4'd15, 18'sd0, 1'b0);
        send_item(adsr_pkg::OP_TICK, 4'd10, 18'sd0, 1'b0);

        // random phases: held gates per channel with noise and control items
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            set_phase(p);
            if (p == 7) calm = 1;
            for (int k = 0; k < 106; k++) begin
                pick = $urandom_range(0, 99);
                ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, 3);
                if (pick < 82) begin
                    if ($urandom_range(0, 9) == 0)
                        chan_gate[ch] = ($urandom_range(0, 1) != 0) ? pick_gate() : 18'sd0;
                    g = ($urandom_range(0, 19) == 0) ? pick_gate() : chan_gate[ch];
                    send_item(adsr_pkg::OP_TICK, 4'(ch), g, $urandom_range(0, 19) == 0);
                end else if (pick < 90) begin
                    g = ($urandom_range(0, 1) != 0) ? pick_gate() : 18'sd0;
                    send_item(adsr_pkg::OP_GATE, 4'($urandom()), g,
                              1'($urandom_range(0, 1)));
                end else if (pick < 97) begin
                    send_item(adsr_pkg::OP_BANG, 4'($urandom()), 18'($urandom()),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_item(OP_NONE, 4'($urandom()), 18'($urandom()),
                              1'($urandom_range(0, 1)));
                end
            end
        end
        wait_idle();
        if (board.fails == 0 && board.pending_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[adsr_envelope_generator_core.f]
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_div.sv
hw/rtl/adsr_mul.sv
hw/rtl/adsr_envelope_generator_core.sv
sim/testbench.sv
